// ----- design/bbe_pkg.sv -----
// ----------------------------------------------------------------------------
// bbe_pkg: shared types and constants for the edge-aware 3x3 box blur
// Holds field widths, register indexes, the job record that travels from the
// front end to the back end, and the reciprocal table used for the means.
// ----------------------------------------------------------------------------
`default_nettype none

package bbe_pkg;

  // Field and state widths.
  localparam int CH_W           = 8;
  localparam int PIX_W          = 3 * CH_W;
  localparam int FW_W           = 11;
  localparam int FH_W           = 13;
  localparam int ROW_W          = 13;
  localparam int POS_W          = 14;
  localparam int MAX_FRAME_ROWS = 4096;
  localparam int RESET_WIDTH    = 1024;
  localparam int RESET_HEIGHT   = 1024;

  // Window geometry.
  localparam int WIN       = 3;
  localparam int WIN_CELLS = WIN * WIN;

  // Mean arithmetic: sum of nine 8-bit values, numerator 2*sum+count.
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int NUM_W       = SUM_W + 1;
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = 18;
  localparam int PROD_W      = NUM_W + RECIP_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // Item kinds.
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // Job queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // One result to be computed: the window, which rows and columns lie
  // inside the frame, and whether it is the frame's final pixel.
  typedef struct packed {
    logic [WIN_CELLS-1:0][PIX_W-1:0] win;
    logic [WIN-1:0]                  row_ok;
    logic [WIN-1:0]                  col_ok;
    logic                            last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // ceil(2^RECIP_SHIFT / (2*count)); exact for numerators below 2^13.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    case (cnt)
      4'd2:    r = 18'd65536;
      4'd3:    r = 18'd43691;
      4'd4:    r = 18'd32768;
      4'd5:    r = 18'd26215;
      4'd6:    r = 18'd21846;
      4'd7:    r = 18'd18725;
      4'd8:    r = 18'd16384;
      4'd9:    r = 18'd14564;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/bbe_queue.sv -----
// ----------------------------------------------------------------------------
// bbe_queue: short job queue between the front and back ends
// A small register FIFO that lets the front end keep accepting pixels while
// the back end waits on a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bbe_pkg::job_t    push_job,
  input  logic             pop,
  output bbe_pkg::job_t    head_job,
  output bbe_pkg::q_status_t status
);
  import bbe_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign head_job     = entries[rd_ptr];
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

`default_nettype wire

// ----- design/bbe_front.sv -----
// ----------------------------------------------------------------------------
// bbe_front: pixel intake, line stores and window for the box blur
// Tracks the raster position, keeps the two line stores and the 3x3 window,
// and queues one job for each pixel whose result is due.
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_front #(
  parameter int MAX_LINE_PIXELS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [bbe_pkg::CH_W-1:0]        red_in,
  input  logic [bbe_pkg::CH_W-1:0]        green_in,
  input  logic [bbe_pkg::CH_W-1:0]        blue_in,
  input  bbe_pkg::q_status_t              q_status,
  output logic                            q_push,
  output bbe_pkg::job_t                   q_job
);
  import bbe_pkg::*;

  localparam int              COL_W   = (MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1;
  localparam logic [POS_W-1:0] MAX_PIX = POS_W'(MAX_LINE_PIXELS);

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [COL_W-1:0] column_index, column_index_next;
  logic [ROW_W-1:0] row_index, row_index_next;
  logic [WIN_CELLS-1:0][PIX_W-1:0] window_pixels, window_pixels_next;

  logic [PIX_W-1:0] upper_line_store [MAX_LINE_PIXELS];
  logic [PIX_W-1:0] lower_line_store [MAX_LINE_PIXELS];
  logic [PIX_W-1:0] upper_rd, lower_rd;
  logic             bypass;
  logic [PIX_W-1:0] bypass_upper, bypass_lower;

  logic [FW_W-1:0]  eff_w;
  logic [FH_W-1:0]  eff_h;
  logic [POS_W-1:0] w_ext, col_ext, cc;
  logic [COL_W-1:0] col_eff;
  logic [ROW_W-1:0] cr;
  logic             accept, take, draining, col_is_zero, has_result, wraps, last;
  logic [PIX_W-1:0] pix, top, mid;
  logic [WIN-1:0]   row_ok, col_ok;

  // Effective frame size: zero acts as one, oversize is clipped.
  always_comb begin
    if (frame_width == '0) begin
      eff_w = FW_W'(1);
    end else if (POS_W'(frame_width) > MAX_PIX) begin
      eff_w = FW_W'(MAX_LINE_PIXELS);
    end else begin
      eff_w = frame_width;
    end
    if (frame_height == '0) begin
      eff_h = FH_W'(1);
    end else if (frame_height > FH_W'(MAX_FRAME_ROWS)) begin
      eff_h = FH_W'(MAX_FRAME_ROWS);
    end else begin
      eff_h = frame_height;
    end
  end

  // Classify the item and locate the center pixel whose result is due.
  always_comb begin
    w_ext       = POS_W'(eff_w);
    col_ext     = POS_W'(column_index);
    col_eff     = (col_ext >= w_ext) ? '0 : column_index;
    col_is_zero = (col_eff == '0);
    draining    = (row_index >= eff_h);
    accept      = in_valid && !in_stall;
    take        = accept && !(mode == MODE_DRAIN && !draining);
    pix         = draining ? '0 : {red_in, green_in, blue_in};
    top         = bypass ? bypass_upper : upper_rd;
    mid         = bypass ? bypass_lower : lower_rd;
    if (col_is_zero) begin
      cc         = w_ext - POS_W'(1);
      cr         = row_index - ROW_W'(2);
      has_result = (row_index >= ROW_W'(2));
    end else begin
      cc         = POS_W'(col_eff) - POS_W'(1);
      cr         = row_index - ROW_W'(1);
      has_result = (row_index >= ROW_W'(1));
    end
    wraps  = (POS_W'(col_eff) + POS_W'(1)) >= w_ext;
    last   = has_result && (cr == ROW_W'(eff_h) - ROW_W'(1)) && (cc == w_ext - POS_W'(1));
    row_ok = {(POS_W'(cr) + POS_W'(1)) < POS_W'(eff_h), cr < ROW_W'(eff_h), cr != '0};
    col_ok = {(cc + POS_W'(1)) < w_ext, cc < w_ext, cc != '0};
  end

  // Window shifts left; the new right column is top, middle and new pixel.
  always_comb begin
    for (int r = 0; r < WIN; r++) begin
      window_pixels_next[r*WIN]   = window_pixels[r*WIN+1];
      window_pixels_next[r*WIN+1] = window_pixels[r*WIN+2];
    end
    window_pixels_next[2]         = top;
    window_pixels_next[WIN+2]     = mid;
    window_pixels_next[2*WIN+2]   = pix;
  end

  // Next raster position; a register write or the last result restarts.
  always_comb begin
    column_index_next = column_index;
    row_index_next    = row_index;
    if (take) begin
      if (last) begin
        column_index_next = '0;
        row_index_next    = '0;
      end else if (wraps) begin
        column_index_next = '0;
        row_index_next    = row_index + ROW_W'(1);
      end else begin
        column_index_next = COL_W'(POS_W'(col_eff) + POS_W'(1));
      end
    end
    if (cfg_write && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
      column_index_next = '0;
      row_index_next    = '0;
    end
  end

  // Line stores: read the next item's column each cycle, write on take.
  always_ff @(posedge clk) begin
    if (take) begin
      upper_line_store[col_eff] <= mid;
      lower_line_store[col_eff] <= pix;
    end
    upper_rd <= upper_line_store[column_index_next];
    lower_rd <= lower_line_store[column_index_next];
  end

  // Forward a write that lands on the address being read.
  always_ff @(posedge clk) begin
    bypass_upper <= mid;
    bypass_lower <= pix;
    if (rst) begin
      bypass <= 1'b0;
    end else begin
      bypass <= take && (column_index_next == col_eff);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(RESET_WIDTH);
      frame_height <= FH_W'(RESET_HEIGHT);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Position and window.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index  <= '0;
      row_index     <= '0;
      window_pixels <= '0;
    end else begin
      column_index <= column_index_next;
      row_index    <= row_index_next;
      if (take) begin
        window_pixels <= window_pixels_next;
      end
    end
  end

  assign in_stall     = q_status.full;
  assign q_push       = take && has_result;
  assign q_job.win    = window_pixels_next;
  assign q_job.row_ok = row_ok;
  assign q_job.col_ok = col_ok;
  assign q_job.last   = last;

endmodule

`default_nettype wire

// ----- design/bbe_back.sv -----
// ----------------------------------------------------------------------------
// bbe_back: neighborhood mean pipeline for the box blur
// Sums the in-frame window pixels, scales by a reciprocal of twice the count
// and holds the rounded means in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_back (
  input  logic                      clk,
  input  logic                      rst,
  input  bbe_pkg::job_t             head_job,
  input  bbe_pkg::q_status_t        q_status,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bbe_pkg::CH_W-1:0]  red_out,
  output logic [bbe_pkg::CH_W-1:0]  green_out,
  output logic [bbe_pkg::CH_W-1:0]  blue_out,
  output logic                      last_of_frame
);
  import bbe_pkg::*;

  logic               advance;
  logic [SUM_W-1:0]   sum_r, sum_g, sum_b;
  logic [1:0]         n_rows, n_cols;
  logic [CNT_W-1:0]   cnt;

  logic               a_valid, a_last;
  logic [NUM_W-1:0]   a_num_r, a_num_g, a_num_b;
  logic [RECIP_W-1:0] a_recip;

  logic               b_valid, b_last;
  logic [PROD_W-1:0]  b_prod_r, b_prod_g, b_prod_b;

  // The whole pipeline moves when the output register is free or taken.
  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !q_status.empty;

  // Masked channel sums and neighbor count of the head job.
  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN; c++) begin
        if (head_job.row_ok[r] && head_job.col_ok[c]) begin
          sum_r = sum_r + SUM_W'(head_job.win[r*WIN+c][2*CH_W +: CH_W]);
          sum_g = sum_g + SUM_W'(head_job.win[r*WIN+c][CH_W +: CH_W]);
          sum_b = sum_b + SUM_W'(head_job.win[r*WIN+c][0 +: CH_W]);
        end
      end
    end
    n_rows = 2'($countones(head_job.row_ok));
    n_cols = 2'($countones(head_job.col_ok));
    cnt    = CNT_W'(n_rows) * CNT_W'(n_cols);
    if (cnt == '0) begin
      cnt = CNT_W'(1);
    end
  end

  // Pipeline data: numerator, then product, then rounded mean.
  always_ff @(posedge clk) begin
    if (advance) begin
      a_num_r  <= {sum_r, 1'b0} + NUM_W'(cnt);
      a_num_g  <= {sum_g, 1'b0} + NUM_W'(cnt);
      a_num_b  <= {sum_b, 1'b0} + NUM_W'(cnt);
      a_recip  <= recip(cnt);
      a_last   <= head_job.last;
      b_prod_r <= PROD_W'(a_num_r) * PROD_W'(a_recip);
      b_prod_g <= PROD_W'(a_num_g) * PROD_W'(a_recip);
      b_prod_b <= PROD_W'(a_num_b) * PROD_W'(a_recip);
      b_last   <= a_last;
      red_out       <= b_prod_r[RECIP_SHIFT +: CH_W];
      green_out     <= b_prod_g[RECIP_SHIFT +: CH_W];
      blue_out      <= b_prod_b[RECIP_SHIFT +: CH_W];
      last_of_frame <= b_last;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= pop;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

endmodule

`default_nettype wire

// ----- design/box_blur_3x3_edge_aware.sv -----
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware: streaming 3x3 box blur with frame-edge masking
// Front end with line stores and window, a four-entry job queue, and a
// three-stage mean pipeline ending in the output register.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock at full rate; the front end
// takes a new item every cycle unless the four-entry job queue is full, which
// only happens while the output is stalled. The line stores are read ahead
// at the next item's column, so no read wait stands in the intake. The
// result for pixel n is formed when item n+width+1 is accepted, is queued,
// and reaches the output register through the sum, multiply and scale
// stages. Send width+1 drain items after the frame; drain items before that
// are dropped. The line stores need no clearing after reset: entries never
// written are only read for masked neighbors. Write frame_width and
// frame_height only while idle; each write restarts the frame.
`default_nettype none

module box_blur_3x3_edge_aware #(
  parameter int MAX_LINE_PIXELS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [bbe_pkg::CH_W-1:0]        red_in,
  input  logic [bbe_pkg::CH_W-1:0]        green_in,
  input  logic [bbe_pkg::CH_W-1:0]        blue_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bbe_pkg::CH_W-1:0]        red_out,
  output logic [bbe_pkg::CH_W-1:0]        green_out,
  output logic [bbe_pkg::CH_W-1:0]        blue_out,
  output logic                            last_of_frame
);
  import bbe_pkg::*;

  logic      q_push;
  logic      q_pop;
  job_t      q_job;
  job_t      head_job;
  q_status_t q_status;

  // Registers are always writable.
  assign cfg_ready = 1'b1;

  // Front end: position, line stores, window.
  bbe_front #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .q_status (q_status),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  // Job queue.
  bbe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(q_job),
    .pop     (q_pop),
    .head_job(head_job),
    .status  (q_status)
  );

  // Back end: means and output register.
  bbe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_job     (head_job),
    .q_status     (q_status),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .last_of_frame(last_of_frame)
  );

  // The front end never pushes into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_status.full))
    else $error("job pushed into a full queue");

  // The back end never pops an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_status.empty))
    else $error("job popped from an empty queue");

  // An empty queue stays empty unless a job is pushed.
  a_empty_holds: assert property (@(posedge clk) disable iff (rst)
    (q_status.empty && !q_push) |=> q_status.empty)
    else $error("queue filled without a push");

endmodule

`default_nettype wire
